// ===== hw/rtl/nfmc_pkg.sv =====
package nfmc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SEED      = 3'd0;
  localparam logic [2:0] CFG_GAIN      = 3'd1;
  localparam logic [2:0] CFG_COEF_ONE  = 3'd2;
  localparam logic [2:0] CFG_COEF_TWO  = 3'd3;
  localparam logic [2:0] CFG_PAY_LEN   = 3'd4;

  // configuration reset values
  localparam logic [31:0] SEED_RST     = 32'h0000_0000;
  localparam logic [15:0] GAIN_RST     = 16'hfc82;
  localparam logic [15:0] COEF_ONE_RST = 16'h0978;
  localparam logic [15:0] COEF_TWO_RST = 16'he541;
  localparam logic [31:0] PAY_LEN_RST  = 32'd199028;

  // state seeds and match constants
  localparam logic [31:0] CHAIN_INIT   = 32'h4ea2_1e71;
  localparam logic [31:0] ACC_INIT     = 32'hcc0a_144b;
  localparam logic [15:0] MIXH_INIT    = 16'hf541;
  localparam logic [15:0] MIXL_INIT    = 16'h878d;
  localparam logic [31:0] RSUM_INIT    = 32'ha3bc_64e4;
  localparam logic [15:0] ROT_OFFSET   = 16'd3;
  localparam logic [31:0] MAGIC_HIGH   = 32'h735f_0000;
  localparam logic [31:0] MAGIC_TARGET = 32'h7fff_ffff;
  localparam logic [15:0] LOW_TARGET   = 16'hffff;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic filt_hi;
    logic filt_lo;
    logic mix_a;
    logic mix_b;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } status_t;

  // configuration values handed to the datapath
  typedef struct packed {
    logic [31:0] seed;
    logic [15:0] gain;
    logic [15:0] coef_one;
    logic [15:0] coef_two;
    logic [31:0] pay_len;
  } cfg_t;

endpackage

// ===== hw/rtl/nfmc_ctrl.sv =====
module nfmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nfmc_pkg::status_t status,
  output nfmc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT_HI,
    ST_FILT_LO,
    ST_MIX_A,
    ST_MIX_B
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // command decode
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ST_FILT_HI;
        end
      end
      ST_FILT_HI: begin
        cmd.filt_hi = 1'b1;
        state_nxt   = ST_FILT_LO;
      end
      ST_FILT_LO: begin
        cmd.filt_lo = 1'b1;
        state_nxt   = ST_MIX_A;
      end
      ST_MIX_A: begin
        cmd.mix_a = 1'b1;
        state_nxt = ST_MIX_B;
      end
      ST_MIX_B: begin
        // wait here while the previous result is still held
        cmd.mix_b = status.out_free;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/nfmc_dpath.sv =====
module nfmc_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  nfmc_pkg::cmd_t    cmd,
  output nfmc_pkg::status_t status,
  input  nfmc_pkg::cfg_t    cfg,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic              in_final,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_checksum,
  output logic              out_match
);

  // item registers
  logic [7:0]  byte_r;
  logic        final_r;
  logic [15:0] hi_r;

  // checksum state
  logic [31:0] chain_r;
  logic [31:0] acc_r;
  logic [15:0] mixh_r;
  logic [15:0] mixl_r;
  logic [31:0] rsum_r;
  logic [15:0] rotb_r;
  logic [15:0] rcnt_r;
  logic [15:0] prev1_r;
  logic [15:0] prev2_r;

  // result register
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_match_r;

  logic [3:0]  nib;
  logic [15:0] filt_y;
  logic [31:0] mix_t;
  logic [31:0] mix_w;
  logic [15:0] rcnt_nxt;
  logic [4:0]  rot_amt;
  logic [63:0] rot_dbl;
  logic [31:0] acc_nxt;
  logic [15:0] mixh_nxt;
  logic [15:0] mixl_nxt;
  logic [31:0] sel_word;
  logic [31:0] rsum_nxt;
  logic [15:0] low_sum;
  logic [31:0] magic;
  logic        match_nxt;

  function automatic logic [31:0] MAGIC_SUM(input logic [31:0] len);
    MAGIC_SUM = nfmc_pkg::MAGIC_HIGH + len;
  endfunction

  // two-tap filter, only the low 16 bits of each product matter
  always_comb begin
    nib    = cmd.filt_hi ? byte_r[7:4] : byte_r[3:0];
    filt_y = 16'({12'd0, nib} * cfg.gain) + 16'(prev1_r * cfg.coef_one)
           + 16'(prev2_r * cfg.coef_two);
  end

  // first half of the mixing round: rotate and accumulate
  always_comb begin
    mix_t    = chain_r + rsum_r;
    mix_w    = mix_t ^ {mixh_r, mixl_r};
    rcnt_nxt = rcnt_r + 16'd1;
    rot_amt  = 5'(rcnt_nxt + rotb_r);
    rot_dbl  = {mix_w, mix_w} << rot_amt;
    acc_nxt  = rot_dbl[63:32] + acc_r;
  end

  // second half: mix words, select, running sum and the final match test
  always_comb begin
    mixh_nxt  = acc_r[31:16] ^ chain_r[31:16] ^ rsum_r[31:16];
    mixl_nxt  = acc_r[15:0] ^ chain_r[15:0] ^ rsum_r[15:0];
    sel_word  = (chain_r & acc_r) | (~chain_r & {mixh_nxt, mixl_nxt});
    rsum_nxt  = sel_word + rsum_r;
    low_sum   = 16'(acc_r + cfg.pay_len);
    magic     = MAGIC_SUM(cfg.pay_len);
    match_nxt = final_r && (low_sum == nfmc_pkg::LOW_TARGET)
             && ((acc_r ^ magic) == nfmc_pkg::MAGIC_TARGET);
  end

  // item capture and filter stages
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r  <= in_byte;
      final_r <= in_final;
    end
    if (cmd.filt_hi) begin
      hi_r <= filt_y;
    end
  end

  // checksum state, reseeded on reset and on a start beat
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.accept && in_start)) begin
      chain_r <= nfmc_pkg::CHAIN_INIT + (rst_n ? cfg.seed : nfmc_pkg::SEED_RST);
      acc_r   <= nfmc_pkg::ACC_INIT;
      mixh_r  <= nfmc_pkg::MIXH_INIT;
      mixl_r  <= nfmc_pkg::MIXL_INIT;
      rsum_r  <= nfmc_pkg::RSUM_INIT;
      rotb_r  <= (rst_n ? cfg.seed[15:0] : nfmc_pkg::SEED_RST[15:0])
               + nfmc_pkg::ROT_OFFSET;
      rcnt_r  <= '0;
      prev1_r <= '0;
      prev2_r <= '0;
    end else begin
      if (cmd.filt_hi || cmd.filt_lo) begin
        prev2_r <= prev1_r;
        prev1_r <= filt_y;
      end
      if (cmd.filt_lo) begin
        chain_r <= chain_r + {hi_r, filt_y};
      end
      if (cmd.mix_a) begin
        rcnt_r <= rcnt_nxt;
        acc_r  <= acc_nxt;
      end
      if (cmd.mix_b) begin
        mixh_r <= mixh_nxt;
        mixl_r <= mixl_nxt;
        rsum_r <= rsum_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.mix_b) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.mix_b) begin
      out_data_r  <= acc_r;
      out_match_r <= match_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_checksum    = out_data_r;
  assign out_match       = out_match_r;

endmodule

// ===== hw/rtl/nibble_filter_mix_checksum.sv =====
// nibble_filter_mix_checksum: byte-serial filtered checksum with final match test
// sequencing: the sequencer steps one filter multiply-add per nibble (FILT_HI, FILT_LO)
//   and a mixing round (MIX_A, MIX_B); the result is registered after MIX_B, which waits
//   while the previous result is still held; a new byte is accepted only in idle
// reset: synchronous active-low rst_n restores the register defaults and seeds
//   all checksum state; no result is pending after reset
module nibble_filter_mix_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] start_req
  input  logic        in_tlast,   // final_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] checksum
  output logic [0:0]  out_tuser,  // [0] match
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  nfmc_pkg::cfg_t    cfg_r;
  nfmc_pkg::cmd_t    cmd;
  nfmc_pkg::status_t status;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed     <= nfmc_pkg::SEED_RST;
      cfg_r.gain     <= nfmc_pkg::GAIN_RST;
      cfg_r.coef_one <= nfmc_pkg::COEF_ONE_RST;
      cfg_r.coef_two <= nfmc_pkg::COEF_TWO_RST;
      cfg_r.pay_len  <= nfmc_pkg::PAY_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        nfmc_pkg::CFG_SEED:     cfg_r.seed     <= cfg_wdata;
        nfmc_pkg::CFG_GAIN:     cfg_r.gain     <= cfg_wdata[15:0];
        nfmc_pkg::CFG_COEF_ONE: cfg_r.coef_one <= cfg_wdata[15:0];
        nfmc_pkg::CFG_COEF_TWO: cfg_r.coef_two <= cfg_wdata[15:0];
        nfmc_pkg::CFG_PAY_LEN:  cfg_r.pay_len  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  nfmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nfmc_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg_r),
    .in_byte      (in_tdata),
    .in_start     (in_tuser[0]),
    .in_final     (in_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_checksum (out_tdata),
    .out_match    (out_tuser[0])
  );

endmodule
